FILE: hw/rtl/psa_pkg.sv
// shared types, constants and helpers for the poisson stencil assembly unit
package psa_pkg;

  localparam int unsigned MaxResDefault = 64;

  localparam int unsigned ResW     = 7;
  localparam int unsigned InvW     = 24;
  localparam int unsigned CellW    = 6;
  localparam int unsigned VelW     = 32;
  localparam int unsigned DiffW    = VelW + 1;
  localparam int unsigned ProdW    = DiffW + InvW + 1;
  localparam int unsigned FracW    = 16;
  localparam int unsigned TermW    = ProdW - FracW;
  localparam int unsigned IdxW     = 18;
  localparam int unsigned CoefW    = 4;
  localparam int unsigned DivW     = 48;
  localparam int unsigned JxW      = CellW + ResW;
  localparam int unsigned AreaW    = 2 * ResW;
  localparam int unsigned KpW      = CellW + AreaW;
  localparam int unsigned NbrN     = 6;
  localparam int unsigned CntW     = 3;
  localparam int unsigned SelW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [ResW-1:0] ResReset = ResW'(32);
  localparam logic [InvW-1:0] InvReset = InvW'(2097152);

  typedef enum logic [CfgIdxW-1:0] {
    CfgResX = 3'd0,
    CfgResY = 3'd1,
    CfgResZ = 3'd2,
    CfgInvX = 3'd3,
    CfgInvY = 3'd4,
    CfgInvZ = 3'd5
  } cfg_idx_e;

  // neighbour order x-, x+, y-, y+, z-, z+
  typedef enum logic [SelW-1:0] {
    NbrXLo = 3'd0,
    NbrXHi = 3'd1,
    NbrYLo = 3'd2,
    NbrYHi = 3'd3,
    NbrZLo = 3'd4,
    NbrZHi = 3'd5
  } nbr_e;

  typedef struct packed {
    logic        [CellW-1:0] cell_x;
    logic        [CellW-1:0] cell_y;
    logic        [CellW-1:0] cell_z;
    logic signed [VelW-1:0]  vel_x_low;
    logic signed [VelW-1:0]  vel_x_high;
    logic signed [VelW-1:0]  vel_y_low;
    logic signed [VelW-1:0]  vel_y_high;
    logic signed [VelW-1:0]  vel_z_low;
    logic signed [VelW-1:0]  vel_z_high;
  } in_item_t;

  typedef struct packed {
    logic        [IdxW-1:0]  row_index;
    logic        [IdxW-1:0]  col_index;
    logic signed [CoefW-1:0] coefficient;
    logic signed [DivW-1:0]  divergence;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [ResW-1:0] res_x;
    logic [ResW-1:0] res_y;
    logic [ResW-1:0] res_z;
    logic [InvW-1:0] inv_x;
    logic [InvW-1:0] inv_y;
    logic [InvW-1:0] inv_z;
  } cfg_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic [IdxW-1:0]  row;
    logic [ResW-1:0]  rx;
    logic [AreaW-1:0] rxry;
    logic [NbrN-1:0]  mask;
  } cell_t;

  function automatic logic [ResW-1:0] eff_res(logic [ResW-1:0] r, int unsigned max_res);
    logic [ResW-1:0] e;
    e = r;
    if (32'(r) > max_res) begin
      e = ResW'(max_res);
    end
    return e;
  endfunction

  function automatic logic [CntW-1:0] count_nbr(logic [NbrN-1:0] m);
    logic [CntW-1:0] c;
    c = '0;
    for (int n = 0; n < NbrN; n++) begin
      c = c + CntW'(m[n]);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/psa_stencil_pipe.sv
// three stage pipeline for neighbour flags and linear cell index, with stall control
module psa_stencil_pipe #(
  parameter int unsigned MaxRes = psa_pkg::MaxResDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  psa_pkg::in_item_t  item_i,
  input  psa_pkg::cfg_t      cfg_i,
  input  logic               take_i,
  output psa_pkg::pipe_ctrl_t ctrl_o,
  output psa_pkg::cell_t     cell_o
);

  // stage 1
  logic                          s1_valid_q;
  logic [psa_pkg::CellW-1:0]     s1_i_q, s1_j_q, s1_k_q;
  logic [psa_pkg::ResW-1:0]      s1_rx_q, s1_ry_q;
  logic [psa_pkg::NbrN-1:0]      s1_mask_q;
  logic [psa_pkg::ResW-1:0]      rx_d, ry_d, rz_d;
  logic [psa_pkg::NbrN-1:0]      mask_d;

  // stage 2
  logic                          s2_valid_q;
  logic [psa_pkg::CellW-1:0]     s2_i_q, s2_k_q;
  logic [psa_pkg::JxW-1:0]       s2_jx_q;
  logic [psa_pkg::AreaW-1:0]     s2_rxry_q;
  logic [psa_pkg::ResW-1:0]      s2_rx_q;
  logic [psa_pkg::NbrN-1:0]      s2_mask_q;

  // stage 3
  logic                          s3_valid_q;
  logic [psa_pkg::IdxW-1:0]      s3_row_q;
  logic [psa_pkg::AreaW-1:0]     s3_rxry_q;
  logic [psa_pkg::ResW-1:0]      s3_rx_q;
  logic [psa_pkg::NbrN-1:0]      s3_mask_q;
  logic [psa_pkg::KpW-1:0]       kp_d;
  logic [psa_pkg::KpW:0]         row_d;

  psa_pkg::pipe_ctrl_t ctrl;

  always_comb begin
    ctrl.en3 = !s3_valid_q || take_i;
    ctrl.en2 = !s2_valid_q || ctrl.en3;
    ctrl.en1 = !s1_valid_q || ctrl.en2;
  end

  assign ctrl_o = ctrl;

  always_comb begin
    rx_d = psa_pkg::eff_res(cfg_i.res_x, MaxRes);
    ry_d = psa_pkg::eff_res(cfg_i.res_y, MaxRes);
    rz_d = psa_pkg::eff_res(cfg_i.res_z, MaxRes);
    mask_d[psa_pkg::NbrXLo] = (item_i.cell_x != '0);
    mask_d[psa_pkg::NbrXHi] = (({1'b0, item_i.cell_x} + psa_pkg::ResW'(1)) < rx_d);
    mask_d[psa_pkg::NbrYLo] = (item_i.cell_y != '0);
    mask_d[psa_pkg::NbrYHi] = (({1'b0, item_i.cell_y} + psa_pkg::ResW'(1)) < ry_d);
    mask_d[psa_pkg::NbrZLo] = (item_i.cell_z != '0);
    mask_d[psa_pkg::NbrZHi] = (({1'b0, item_i.cell_z} + psa_pkg::ResW'(1)) < rz_d);
  end

  always_comb begin
    kp_d  = psa_pkg::KpW'(s2_k_q) * psa_pkg::KpW'(s2_rxry_q);
    row_d = (psa_pkg::KpW+1)'(kp_d) + (psa_pkg::KpW+1)'(s2_jx_q)
          + (psa_pkg::KpW+1)'(s2_i_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (ctrl.en1) s1_valid_q <= accept_i;
      if (ctrl.en2) s2_valid_q <= s1_valid_q;
      if (ctrl.en3) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en1) begin
      s1_i_q    <= item_i.cell_x;
      s1_j_q    <= item_i.cell_y;
      s1_k_q    <= item_i.cell_z;
      s1_rx_q   <= rx_d;
      s1_ry_q   <= ry_d;
      s1_mask_q <= mask_d;
    end
    if (ctrl.en2) begin
      s2_i_q    <= s1_i_q;
      s2_k_q    <= s1_k_q;
      s2_jx_q   <= psa_pkg::JxW'(s1_j_q) * psa_pkg::JxW'(s1_rx_q);
      s2_rxry_q <= psa_pkg::AreaW'(s1_rx_q) * psa_pkg::AreaW'(s1_ry_q);
      s2_rx_q   <= s1_rx_q;
      s2_mask_q <= s1_mask_q;
    end
    if (ctrl.en3) begin
      s3_row_q  <= row_d[psa_pkg::IdxW-1:0];
      s3_rxry_q <= s2_rxry_q;
      s3_rx_q   <= s2_rx_q;
      s3_mask_q <= s2_mask_q;
    end
  end

  always_comb begin
    cell_o.valid = s3_valid_q;
    cell_o.row   = s3_row_q;
    cell_o.rx    = s3_rx_q;
    cell_o.rxry  = s3_rxry_q;
    cell_o.mask  = s3_mask_q;
  end

endmodule

FILE: hw/rtl/psa_div_pipe.sv
// three stage divergence datapath: face differences, scaled terms, sum
module psa_div_pipe (
  input  logic                              clk_i,
  input  psa_pkg::in_item_t                 item_i,
  input  psa_pkg::cfg_t                     cfg_i,
  input  psa_pkg::pipe_ctrl_t               ctrl_i,
  output logic signed [psa_pkg::DivW-1:0]   div_o
);

  logic signed [psa_pkg::DiffW-1:0] dx_q, dy_q, dz_q;
  logic signed [psa_pkg::TermW-1:0] tx_q, ty_q, tz_q;
  logic signed [psa_pkg::DivW-1:0]  div_q;
  logic signed [psa_pkg::ProdW-1:0] px, py, pz;
  logic signed [psa_pkg::InvW:0]    inv_x, inv_y, inv_z;
  logic signed [psa_pkg::DivW-1:0]  sum_d;

  always_comb begin
    inv_x = $signed({1'b0, cfg_i.inv_x});
    inv_y = $signed({1'b0, cfg_i.inv_y});
    inv_z = $signed({1'b0, cfg_i.inv_z});
    px = psa_pkg::ProdW'(dx_q) * psa_pkg::ProdW'(inv_x);
    py = psa_pkg::ProdW'(dy_q) * psa_pkg::ProdW'(inv_y);
    pz = psa_pkg::ProdW'(dz_q) * psa_pkg::ProdW'(inv_z);
    sum_d = psa_pkg::DivW'(tx_q) + psa_pkg::DivW'(ty_q) + psa_pkg::DivW'(tz_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      dx_q <= psa_pkg::DiffW'(item_i.vel_x_high) - psa_pkg::DiffW'(item_i.vel_x_low);
      dy_q <= psa_pkg::DiffW'(item_i.vel_y_high) - psa_pkg::DiffW'(item_i.vel_y_low);
      dz_q <= psa_pkg::DiffW'(item_i.vel_z_high) - psa_pkg::DiffW'(item_i.vel_z_low);
    end
    // floor by 2^16 is the upper part of the product
    if (ctrl_i.en2) begin
      tx_q <= px[psa_pkg::ProdW-1:psa_pkg::FracW];
      ty_q <= py[psa_pkg::ProdW-1:psa_pkg::FracW];
      tz_q <= pz[psa_pkg::ProdW-1:psa_pkg::FracW];
    end
    if (ctrl_i.en3) begin
      div_q <= sum_d;
    end
  end

  assign div_o = div_q;

endmodule

FILE: hw/rtl/psa_result_seq.sv
// result sequencer: one triplet per cycle from the held cell, diagonal last
module psa_result_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  psa_pkg::cell_t                   cell_i,
  input  logic signed [psa_pkg::DivW-1:0]  div_i,
  output logic                             take_o,
  output logic                             res_valid_o,
  output psa_pkg::result_t                 result_o
);

  logic                            hold_q;
  logic [psa_pkg::NbrN-1:0]        mask_q;
  logic [psa_pkg::CntW-1:0]        cnt_q;
  logic [psa_pkg::IdxW-1:0]        row_q;
  logic [psa_pkg::ResW-1:0]        rx_q;
  logic [psa_pkg::AreaW-1:0]       rxry_q;
  logic signed [psa_pkg::DivW-1:0] div_q;
  logic                            out_valid_q;
  psa_pkg::result_t                out_q;

  logic                            take;
  psa_pkg::nbr_e                   sel;
  logic [psa_pkg::IdxW-1:0]        step;
  logic [psa_pkg::IdxW-1:0]        col;
  psa_pkg::result_t                out_d;

  assign take = cell_i.valid && (!hold_q || (mask_q == '0));

  // lowest pending neighbour
  always_comb begin
    sel = psa_pkg::NbrZHi;
    for (int n = psa_pkg::NbrN - 1; n >= 0; n--) begin
      if (mask_q[n]) sel = psa_pkg::nbr_e'(n);
    end
  end

  always_comb begin
    case (sel)
      psa_pkg::NbrXLo: col = row_q - psa_pkg::IdxW'(1);
      psa_pkg::NbrXHi: col = row_q + psa_pkg::IdxW'(1);
      psa_pkg::NbrYLo: col = row_q - psa_pkg::IdxW'(rx_q);
      psa_pkg::NbrYHi: col = row_q + psa_pkg::IdxW'(rx_q);
      psa_pkg::NbrZLo: col = row_q - psa_pkg::IdxW'(rxry_q);
      psa_pkg::NbrZHi: col = row_q + psa_pkg::IdxW'(rxry_q);
      default:         col = row_q;
    endcase
    step = col;
  end

  always_comb begin
    out_d.row_index = row_q;
    if (mask_q != '0) begin
      out_d.col_index   = step;
      out_d.coefficient = psa_pkg::CoefW'(1);
      out_d.divergence  = '0;
      out_d.last        = 1'b0;
    end else begin
      out_d.col_index   = row_q;
      out_d.coefficient = psa_pkg::CoefW'(0) - psa_pkg::CoefW'(cnt_q);
      out_d.divergence  = div_q;
      out_d.last        = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= hold_q;
      if (take) begin
        hold_q <= 1'b1;
        mask_q <= cell_i.mask;
      end else if (hold_q) begin
        if (mask_q == '0) begin
          hold_q <= 1'b0;
        end else begin
          mask_q <= mask_q & (mask_q - psa_pkg::NbrN'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (take) begin
      cnt_q  <= psa_pkg::count_nbr(cell_i.mask);
      row_q  <= cell_i.row;
      rx_q   <= cell_i.rx;
      rxry_q <= cell_i.rxry;
      div_q  <= div_i;
    end
  end

  assign take_o      = take;
  assign res_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: hw/rtl/poisson_stencil_assembly_unit.sv
// top level of the poisson stencil assembly unit: config registers and pipeline wiring
//
// Each accepted cell gives n + 1 results, one per clock on result_o with
// res_valid_o high: one (row, col, +1) triplet per in-grid neighbour in the
// order x-, x+, y-, y+, z-, z+, then the diagonal (row, row, -n) with the
// divergence and last set. The result port cannot be stalled, so the block
// paces itself: a cell holds the single result port for its n + 1 results
// (1 to 7), and busy_o rises once the three-stage front pipeline is full
// behind the sequencer. Cells may be started back to back. Configuration
// is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must
// write it only while no cell is in flight, as the block itself does not
// enforce this.
module poisson_stencil_assembly_unit #(
  parameter int unsigned MaxRes = psa_pkg::MaxResDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  psa_pkg::in_item_t               item_i,
  input  logic                            cfg_we_i,
  input  logic [psa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [psa_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic                            res_valid_o,
  output psa_pkg::result_t                result_o
);

  psa_pkg::cfg_t       cfg_q;
  psa_pkg::pipe_ctrl_t ctrl;
  psa_pkg::cell_t      cell_info;
  logic signed [psa_pkg::DivW-1:0] div;
  logic                take;
  logic                accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.res_x <= psa_pkg::ResReset;
      cfg_q.res_y <= psa_pkg::ResReset;
      cfg_q.res_z <= psa_pkg::ResReset;
      cfg_q.inv_x <= psa_pkg::InvReset;
      cfg_q.inv_y <= psa_pkg::InvReset;
      cfg_q.inv_z <= psa_pkg::InvReset;
    end else if (cfg_we_i) begin
      case (psa_pkg::cfg_idx_e'(cfg_idx_i))
        psa_pkg::CfgResX: cfg_q.res_x <= cfg_wdata_i[psa_pkg::ResW-1:0];
        psa_pkg::CfgResY: cfg_q.res_y <= cfg_wdata_i[psa_pkg::ResW-1:0];
        psa_pkg::CfgResZ: cfg_q.res_z <= cfg_wdata_i[psa_pkg::ResW-1:0];
        psa_pkg::CfgInvX: cfg_q.inv_x <= cfg_wdata_i[psa_pkg::InvW-1:0];
        psa_pkg::CfgInvY: cfg_q.inv_y <= cfg_wdata_i[psa_pkg::InvW-1:0];
        psa_pkg::CfgInvZ: cfg_q.inv_z <= cfg_wdata_i[psa_pkg::InvW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = start_i && ctrl.en1;
  assign busy_o = !ctrl.en1;

  psa_stencil_pipe #(
    .MaxRes(MaxRes)
  ) u_stencil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .take_i  (take),
    .ctrl_o  (ctrl),
    .cell_o  (cell_info)
  );

  psa_div_pipe u_div (
    .clk_i (clk_i),
    .item_i(item_i),
    .cfg_i (cfg_q),
    .ctrl_i(ctrl),
    .div_o (div)
  );

  psa_result_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_info),
    .div_i      (div),
    .take_o     (take),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

endmodule

FILE: verif/tb_poisson_stencil_assembly_unit.sv
// testbench for the poisson stencil assembly unit: stencil and divergence prediction and checking
module tb_poisson_stencil_assembly_unit;

  localparam int unsigned GridMax = psa_pkg::MaxResDefault;
  localparam logic [psa_pkg::CfgIdxW-1:0] CfgSpare = 3'd7;
  localparam logic signed [psa_pkg::VelW-1:0] VelMin = 32'sh8000_0000;
  localparam logic signed [psa_pkg::VelW-1:0] VelMax = 32'sh7fff_ffff;
  localparam logic [psa_pkg::InvW-1:0] InvMax = 24'hff_ffff;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  psa_pkg::in_item_t             item_i = '0;
  logic                          cfg_we_i = 1'b0;
  logic [psa_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [psa_pkg::CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                          res_valid_o;
  psa_pkg::result_t              result_o;

  logic [psa_pkg::ResW-1:0] grid_res [3];
  logic [psa_pkg::InvW-1:0] inv_spacing [3];

  psa_pkg::in_item_t pending_cells [$];
  psa_pkg::result_t  stencil_q [$];
  psa_pkg::result_t  want;
  int unsigned gap_left;
  int unsigned gap_max = 0;
  int unsigned err_cnt = 0;

  poisson_stencil_assembly_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** poisson_stencil_assembly_unit: FAILED **");
    $finish;
  end

  function automatic int unsigned sat_res(logic [psa_pkg::ResW-1:0] r);
    return (int'(r) > GridMax) ? GridMax : int'(r);
  endfunction

  function automatic logic [psa_pkg::IdxW-1:0] cell_index(int unsigned i, int unsigned j,
                                                          int unsigned k, int unsigned rx,
                                                          int unsigned ry);
    return psa_pkg::IdxW'(k * rx * ry + j * rx + i);
  endfunction

  // (high - low) * reciprocal spacing, floored to Q32.16
  function automatic logic signed [psa_pkg::DivW-1:0] flux_term(
      logic signed [psa_pkg::VelW-1:0] lo,
      logic signed [psa_pkg::VelW-1:0] hi,
      logic [psa_pkg::InvW-1:0] inv);
    logic signed [psa_pkg::DiffW-1:0] d;
    logic signed [psa_pkg::ProdW-1:0] p;
    d = psa_pkg::DiffW'(hi) - psa_pkg::DiffW'(lo);
    p = d * $signed({1'b0, inv});
    return psa_pkg::DivW'(p >>> psa_pkg::FracW);
  endfunction

  task automatic add_nbr(logic [psa_pkg::IdxW-1:0] row, logic [psa_pkg::IdxW-1:0] col);
    stencil_q.push_back('{row_index: row, col_index: col, coefficient: psa_pkg::CoefW'(1),
                          divergence: '0, last: 1'b0});
  endtask

  task automatic predict_stencil(psa_pkg::in_item_t c);
    int unsigned i, j, k, rx, ry, rz, n0;
    logic [psa_pkg::IdxW-1:0] row;
    logic signed [psa_pkg::DivW-1:0] div;
    i = 32'(c.cell_x);
    j = 32'(c.cell_y);
    k = 32'(c.cell_z);
    rx = sat_res(grid_res[0]);
    ry = sat_res(grid_res[1]);
    rz = sat_res(grid_res[2]);
    row = cell_index(i, j, k, rx, ry);
    n0 = stencil_q.size();
    if (i > 0) add_nbr(row, cell_index(i - 1, j, k, rx, ry));
    if (i + 1 < rx) add_nbr(row, cell_index(i + 1, j, k, rx, ry));
    if (j > 0) add_nbr(row, cell_index(i, j - 1, k, rx, ry));
    if (j + 1 < ry) add_nbr(row, cell_index(i, j + 1, k, rx, ry));
    if (k > 0) add_nbr(row, cell_index(i, j, k - 1, rx, ry));
    if (k + 1 < rz) add_nbr(row, cell_index(i, j, k + 1, rx, ry));
    div = flux_term(c.vel_x_low, c.vel_x_high, inv_spacing[0])
        + flux_term(c.vel_y_low, c.vel_y_high, inv_spacing[1])
        + flux_term(c.vel_z_low, c.vel_z_high, inv_spacing[2]);
    stencil_q.push_back('{row_index: row, col_index: row,
                          coefficient: -psa_pkg::CoefW'(stencil_q.size() - n0),
                          divergence: div, last: 1'b1});
  endtask

  // cell driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (start_i && !busy_o) begin
        predict_stencil(item_i);
        gap_left = $urandom_range(0, gap_max);
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        item_i  <= pending_cells.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (stencil_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected transfer, expected none, actual %p", $time, result_o);
      end else begin
        want = stencil_q.pop_front();
        check_field("row_index", 64'(want.row_index), 64'(result_o.row_index));
        check_field("col_index", 64'(want.col_index), 64'(result_o.col_index));
        check_field("coefficient", 64'(want.coefficient), 64'(result_o.coefficient));
        check_field("divergence", 64'(want.divergence), 64'(result_o.divergence));
        check_field("last", 64'(want.last), 64'(result_o.last));
      end
    end
  end

  task automatic write_reg(logic [psa_pkg::CfgIdxW-1:0] idx,
                           logic [psa_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      psa_pkg::CfgResX: grid_res[0] = data[psa_pkg::ResW-1:0];
      psa_pkg::CfgResY: grid_res[1] = data[psa_pkg::ResW-1:0];
      psa_pkg::CfgResZ: grid_res[2] = data[psa_pkg::ResW-1:0];
      psa_pkg::CfgInvX: inv_spacing[0] = data[psa_pkg::InvW-1:0];
      psa_pkg::CfgInvY: inv_spacing[1] = data[psa_pkg::InvW-1:0];
      psa_pkg::CfgInvZ: inv_spacing[2] = data[psa_pkg::InvW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [psa_pkg::CfgDataW-1:0] rx, logic [psa_pkg::CfgDataW-1:0] ry,
                          logic [psa_pkg::CfgDataW-1:0] rz, logic [psa_pkg::CfgDataW-1:0] ix,
                          logic [psa_pkg::CfgDataW-1:0] iy, logic [psa_pkg::CfgDataW-1:0] iz);
    write_reg(psa_pkg::CfgResX, rx);
    write_reg(psa_pkg::CfgResY, ry);
    write_reg(psa_pkg::CfgResZ, rz);
    write_reg(psa_pkg::CfgInvX, ix);
    write_reg(psa_pkg::CfgInvY, iy);
    write_reg(psa_pkg::CfgInvZ, iz);
  endtask

  // wait until every queued cell is out and every result is back
  task automatic drain();
    @(negedge clk_i);
    while (pending_cells.size() > 0 || start_i || stencil_q.size() > 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic psa_pkg::in_item_t mk_cell(int unsigned i, int unsigned j, int unsigned k,
      logic signed [psa_pkg::VelW-1:0] xl, logic signed [psa_pkg::VelW-1:0] xh,
      logic signed [psa_pkg::VelW-1:0] yl, logic signed [psa_pkg::VelW-1:0] yh,
      logic signed [psa_pkg::VelW-1:0] zl, logic signed [psa_pkg::VelW-1:0] zh);
    return '{cell_x: psa_pkg::CellW'(i), cell_y: psa_pkg::CellW'(j),
             cell_z: psa_pkg::CellW'(k),
             vel_x_low: xl, vel_x_high: xh, vel_y_low: yl, vel_y_high: yh,
             vel_z_low: zl, vel_z_high: zh};
  endfunction

  function automatic logic signed [psa_pkg::VelW-1:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return VelMin;
      1: return VelMax;
      2: return '0;
      3: return psa_pkg::VelW'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned rand_coord(logic [psa_pkg::ResW-1:0] r);
    int unsigned e;
    e = sat_res(r);
    if (e > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, e - 1);
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [psa_pkg::CfgDataW-1:0] rand_word();
    return psa_pkg::CfgDataW'($urandom);
  endfunction

  function automatic logic [psa_pkg::CfgDataW-1:0] rand_res(int unsigned lo, int unsigned hi);
    return psa_pkg::CfgDataW'($urandom_range(lo, hi));
  endfunction

  task automatic run_cells(int unsigned n, int unsigned gmax);
    gap_max = gmax;
    repeat (n) begin
      pending_cells.push_back(mk_cell(rand_coord(grid_res[0]), rand_coord(grid_res[1]),
                                      rand_coord(grid_res[2]), rand_vel(), rand_vel(),
                                      rand_vel(), rand_vel(), rand_vel(), rand_vel()));
    end
    drain();
  endtask

  initial begin
    grid_res    = '{psa_pkg::ResReset, psa_pkg::ResReset, psa_pkg::ResReset};
    inv_spacing = '{psa_pkg::InvReset, psa_pkg::InvReset, psa_pkg::InvReset};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid of 32 cells per axis, spacing 1/32
    pending_cells.push_back(mk_cell(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cells.push_back(mk_cell(31, 31, 31, VelMin, VelMax, 0, 0, 0, 0));
    pending_cells.push_back(mk_cell(15, 16, 17, VelMax, VelMin, VelMin, VelMax, VelMax, VelMin));
    pending_cells.push_back(mk_cell(63, 63, 63, VelMin, VelMax, VelMin, VelMax, VelMin, VelMax));
    pending_cells.push_back(mk_cell(31, 0, 0, 0, -1, 0, 1, 0, 0));
    pending_cells.push_back(mk_cell(0, 31, 0, 5, 5, -7, -7, 0, 0));
    pending_cells.push_back(mk_cell(0, 0, 31, 0, 0, 0, 0, VelMax, VelMax));
    pending_cells.push_back(mk_cell(32, 32, 32, 1, 0, 0, -1, -1, 1));
    pending_cells.push_back(mk_cell(1, 1, 1, VelMax, VelMax, VelMin, VelMin, 0, -1));
    pending_cells.push_back(mk_cell(30, 5, 9, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
    drain();

    // fractional spacing for floor rounding, spare register index ignored
    set_grid(64, 64, 64, 1, InvMax, 24'h01_0001);
    write_reg(CfgSpare, rand_word());
    pending_cells.push_back(mk_cell(0, 0, 0, 0, -1, 0, -1, 0, -1));
    pending_cells.push_back(mk_cell(63, 63, 63, 0, 1, 0, 1, 0, 1));
    pending_cells.push_back(mk_cell(62, 1, 63, VelMax, VelMin, VelMax, VelMin, VelMax, VelMin));
    pending_cells.push_back(mk_cell(5, 63, 0, VelMin, VelMax, VelMin, VelMax, VelMin, VelMax));
    pending_cells.push_back(mk_cell(33, 34, 35, -3, 2, 7, -9, 1, -1));
    drain();

    // single cell, zero resolution, resolution above the limit
    set_grid(1, 1, 1, 0, 0, 0);
    pending_cells.push_back(mk_cell(0, 0, 0, VelMin, VelMax, VelMin, VelMax, VelMin, VelMax));
    pending_cells.push_back(mk_cell(1, 2, 3, 0, 0, 0, 0, 0, 0));
    drain();
    set_grid(24'hff_ff80, 127, 65, InvMax, InvMax, InvMax);
    pending_cells.push_back(mk_cell(0, 0, 0, VelMin, VelMax, VelMin, VelMax, VelMin, VelMax));
    pending_cells.push_back(mk_cell(63, 63, 63, VelMax, VelMin, VelMax, VelMin, VelMax, VelMin));
    pending_cells.push_back(mk_cell(1, 62, 63, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases
    run_cells(50, 0);
    set_grid(64, 64, 64, InvMax, InvMax, InvMax);
    run_cells(50, 5);
    set_grid(rand_res(2, 8), rand_res(2, 8), rand_res(2, 8),
             rand_word(), rand_word(), rand_word());
    run_cells(55, 0);
    set_grid(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    run_cells(55, 5);
    set_grid(64, 1, 64, rand_word(), 0, rand_word());
    run_cells(50, 2);
    set_grid(rand_res(1, 64), rand_res(1, 64), rand_res(1, 64),
             rand_word(), rand_word(), rand_word());
    run_cells(60, 5);

    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("** poisson_stencil_assembly_unit: PASSED **");
    end else begin
      $display("** poisson_stencil_assembly_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/psa_pkg.sv
hw/rtl/psa_stencil_pipe.sv
hw/rtl/psa_div_pipe.sv
hw/rtl/psa_result_seq.sv
hw/rtl/poisson_stencil_assembly_unit.sv
verif/tb_poisson_stencil_assembly_unit.sv
